@@ design/vpad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vpad_pkg;

    localparam int VRAM_DEPTH     = 16384;
    localparam int COLOR_ENTRIES  = 32;
    localparam int REGISTER_COUNT = 16;

    localparam int VRAM_AW   = $clog2(VRAM_DEPTH);
    localparam int COLOR_AW  = $clog2(COLOR_ENTRIES);
    localparam int REG_IDX_W = $clog2(REGISTER_COUNT);
    localparam int PTR_W     = 14;
    localparam int BYTE_W    = 8;
    localparam int COLOR_W   = 12;

    typedef enum logic [1:0] {
        CMD_VRAM_RD  = 2'd0,
        CMD_VRAM_WR  = 2'd1,
        CMD_REG_WR   = 2'd2,
        CMD_COLOR_WR = 2'd3
    } t_cmd;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;
    localparam logic PORT_DATA  = 1'b0;
    localparam logic PORT_CTRL  = 1'b1;

    // memory requests issued by the port decoder for one transaction
    typedef struct packed {
        logic                vram_we;
        logic                vram_re;
        logic [VRAM_AW-1:0]  vram_addr;
        logic [BYTE_W-1:0]   vram_wdata;
        logic                color_we;
        logic [COLOR_AW-1:0] color_addr;
        logic [COLOR_W-1:0]  color_wdata;
    } t_mem_req;

endpackage

`default_nettype wire

@@ design/vpad_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vpad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/vpad_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vpad_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_func,
    input  wire logic                  i_port_select,
    input  wire logic [7:0]            i_bus_byte,
    output vpad_pkg::t_mem_req         o_req
);

    import vpad_pkg::*;

    logic                  r_pending, n_pending;
    logic [BYTE_W-1:0]     r_held, n_held;
    logic [PTR_W-1:0]      r_ptr, n_ptr;
    t_cmd                  r_cmd, n_cmd;
    logic [BYTE_W-1:0]     r_color_lo, n_color_lo;
    logic [BYTE_W-1:0]     r_mode_regs [REGISTER_COUNT];
    logic                  mode_we;
    logic [REG_IDX_W-1:0]  mode_idx;
    logic                  idx_in_range;

    assign idx_in_range = {1'b0, i_bus_byte[3:0]} < 5'(REGISTER_COUNT);
    assign mode_idx     = i_bus_byte[REG_IDX_W-1:0];

    always_comb begin
        n_pending  = r_pending;
        n_held     = r_held;
        n_ptr      = r_ptr;
        n_cmd      = r_cmd;
        n_color_lo = r_color_lo;
        mode_we    = 1'b0;

        o_req             = '0;
        o_req.vram_addr   = r_ptr[VRAM_AW-1:0];
        o_req.vram_wdata  = i_bus_byte;
        o_req.color_addr  = r_ptr[COLOR_AW:1];
        o_req.color_wdata = {i_bus_byte[3:0], r_color_lo};

        if (i_accept) begin
            if (i_port_select == PORT_CTRL) begin
                if (i_func == FUNC_WRITE) begin
                    if (!r_pending) begin
                        n_held    = i_bus_byte;
                        n_pending = 1'b1;
                    end else begin
                        n_pending = 1'b0;
                        n_cmd     = t_cmd'(i_bus_byte[7:6]);
                        n_ptr     = {i_bus_byte[5:0], r_held};
                        mode_we   = (t_cmd'(i_bus_byte[7:6]) == CMD_REG_WR) && idx_in_range;
                    end
                end else begin
                    // status read clears the pair latch
                    n_pending = 1'b0;
                end
            end else begin
                n_ptr = r_ptr + PTR_W'(1);
                if (i_func == FUNC_WRITE) begin
                    if (r_cmd == CMD_COLOR_WR) begin
                        if (!r_ptr[0]) begin
                            n_color_lo = i_bus_byte;
                        end else begin
                            o_req.color_we = 1'b1;
                        end
                    end else begin
                        o_req.vram_we = 1'b1;
                    end
                end else begin
                    o_req.vram_re = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_held     <= '0;
            r_ptr      <= '0;
            r_cmd      <= CMD_VRAM_RD;
            r_color_lo <= '0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_mode_regs[i] <= '0;
            end
        end else begin
            r_pending  <= n_pending;
            r_held     <= n_held;
            r_ptr      <= n_ptr;
            r_cmd      <= n_cmd;
            r_color_lo <= n_color_lo;
            if (mode_we) begin
                r_mode_regs[mode_idx] <= r_held;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/video_port_access_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Video port access decoder: processor side of a control/data port pair.
// A transaction is accepted when start is high and busy is low; its kind is
// given by i_func (0 read, 1 write) and i_port_select (0 data, 1 control),
// with i_bus_byte carrying write data.
// Every transaction returns one result: o_result_valid pulses for one cycle,
// in the cycle after acceptance, with o_read_byte holding the VRAM byte
// for data reads and zero for everything else.
// Throughput is one transaction per cycle while busy is low. The VRAM read
// port is registered; pointer updates land at the same edge as
// the memory write, so back-to-back accesses see each other.
// Reset (synchronous, active low) clears the pair latch, address pointer,
// command code, color latch and mode registers; VRAM and color RAM contents
// are not cleared. busy is high during reset and the cycle that follows.
// Results cannot be held off: the receiver takes each one in its cycle.

module video_port_access_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_func,
    input  wire logic       i_port_select,
    input  wire logic [7:0] i_bus_byte,
    output logic            o_result_valid,
    output logic [7:0]      o_read_byte
);

    import vpad_pkg::*;

    logic                accept;
    t_mem_req            req;
    logic [BYTE_W-1:0]   vram_rdata;
    logic                r_busy;
    logic                r_valid;
    logic                r_was_read;

    assign accept = start && !busy;
    assign busy   = r_busy;

    vpad_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_port_select (i_port_select),
        .i_bus_byte    (i_bus_byte),
        .o_req         (req)
    );

    vpad_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .i_clk     (i_clk),
        .i_we      (req.vram_we),
        .i_wr_addr (req.vram_addr),
        .i_wr_data (req.vram_wdata),
        .i_rd_en   (req.vram_re),
        .i_rd_addr (req.vram_addr),
        .o_rd_data (vram_rdata)
    );

    // color RAM is write-only from this side
    vpad_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (COLOR_ENTRIES)
    ) u_cram (
        .i_clk     (i_clk),
        .i_we      (req.color_we),
        .i_wr_addr (req.color_addr),
        .i_wr_data (req.color_wdata),
        .i_rd_en   (1'b0),
        .i_rd_addr (req.color_addr),
        .o_rd_data ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_valid    <= 1'b0;
            r_was_read <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_valid    <= accept;
            r_was_read <= req.vram_re;
        end
    end

    assign o_result_valid = r_valid;
    assign o_read_byte    = r_was_read ? vram_rdata : '0;

endmodule

`default_nettype wire

@@ design/vpad_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vpad_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       i_func,
    input wire logic       i_port_select,
    input wire logic       o_result_valid,
    input wire logic [7:0] o_read_byte
);

    // every accepted transaction yields a result the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_result_valid)
        else $error("no result after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_result_valid)
        else $error("result without a transaction");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func) |=> (o_read_byte == 8'h00))
        else $error("write returned nonzero byte");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_port_select) |=> (o_read_byte == 8'h00))
        else $error("control port access returned nonzero byte");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_result_valid && busy))
        else $error("activity right after reset");

endmodule

bind video_port_access_decoder vpad_checker u_vpad_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import vpad_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic       is_write;
        logic       is_ctrl;
        logic [7:0] bus_byte;
    } port_access_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       i_func = 1'b0;
    logic       i_port_select = 1'b0;
    logic [7:0] i_bus_byte = 8'h00;
    logic       busy;
    logic       o_result_valid;
    logic [7:0] o_read_byte;

    video_port_access_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_port_select  (i_port_select),
        .i_bus_byte     (i_bus_byte),
        .o_result_valid (o_result_valid),
        .o_read_byte    (o_read_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    port_access_t pending_accesses[$];
    logic [7:0]   expected_reads[$];
    int           idle_pct = 0;
    int           cycle_count = 0;
    int           mismatch_count = 0;
    int           queued_count = 0;

    // predicted chip state, advanced as transactions are accepted
    logic                  pair_waiting = 1'b0;
    logic [7:0]            first_byte = 8'h00;
    logic [PTR_W-1:0]      vram_ptr = '0;
    t_cmd                  cur_cmd = CMD_VRAM_RD;
    logic [7:0]            color_lo = 8'h00;
    logic [7:0]            mode_regs [REGISTER_COUNT];
    logic [7:0]            vram_image [VRAM_DEPTH];
    logic [COLOR_W-1:0]    color_image [COLOR_ENTRIES];
    int n_data_reads = 0, n_vram_writes = 0, n_color_writes = 0;
    int n_ctrl_pairs = 0, n_status_reads = 0;

    // stimulus-side view: only what is needed to keep reads on written VRAM
    logic             plan_pair = 1'b0;
    logic [7:0]       plan_first = 8'h00;
    logic [PTR_W-1:0] plan_ptr = '0;
    t_cmd             plan_cmd = CMD_VRAM_RD;
    bit               vram_written [VRAM_DEPTH];
    logic [PTR_W-1:0] last_burst_addr = '0;

    function automatic logic [7:0] predict_access(input port_access_t a);
        logic [7:0] rd;
        rd = 8'h00;
        if (a.is_ctrl == PORT_CTRL) begin
            if (a.is_write == FUNC_WRITE) begin
                if (!pair_waiting) begin
                    first_byte   = a.bus_byte;
                    pair_waiting = 1'b1;
                end else begin
                    pair_waiting = 1'b0;
                    cur_cmd      = t_cmd'(a.bus_byte[7:6]);
                    vram_ptr     = {a.bus_byte[5:0], first_byte};
                    if (cur_cmd == CMD_REG_WR && int'(a.bus_byte[3:0]) < REGISTER_COUNT)
                        mode_regs[a.bus_byte[3:0]] = first_byte;
                    n_ctrl_pairs++;
                end
            end else begin
                // status read: contents not modeled, but it drops a half-written pair
                pair_waiting = 1'b0;
                n_status_reads++;
            end
        end else begin
            if (a.is_write == FUNC_WRITE) begin
                if (cur_cmd == CMD_COLOR_WR) begin
                    if (!vram_ptr[0]) begin
                        color_lo = a.bus_byte;
                    end else begin
                        color_image[int'(vram_ptr >> 1) % COLOR_ENTRIES] =
                            {a.bus_byte[3:0], color_lo};
                        n_color_writes++;
                    end
                end else begin
                    vram_image[int'(vram_ptr) % VRAM_DEPTH] = a.bus_byte;
                    n_vram_writes++;
                end
            end else begin
                rd = vram_image[int'(vram_ptr) % VRAM_DEPTH];
                n_data_reads++;
            end
            vram_ptr = vram_ptr + 1'b1;
        end
        return rd;
    endfunction

    task automatic queue_access(input logic is_write, input logic is_ctrl,
                                input logic [7:0] bus_byte);
        port_access_t a;
        a.is_write = is_write;
        a.is_ctrl  = is_ctrl;
        a.bus_byte = bus_byte;
        pending_accesses.push_back(a);
        queued_count++;
        if (is_ctrl == PORT_CTRL) begin
            if (is_write == FUNC_WRITE) begin
                if (!plan_pair) begin
                    plan_first = bus_byte;
                    plan_pair  = 1'b1;
                end else begin
                    plan_pair = 1'b0;
                    plan_cmd  = t_cmd'(bus_byte[7:6]);
                    plan_ptr  = {bus_byte[5:0], plan_first};
                end
            end else begin
                plan_pair = 1'b0;
            end
        end else begin
            if (is_write == FUNC_WRITE && plan_cmd != CMD_COLOR_WR)
                vram_written[plan_ptr] = 1'b1;
            plan_ptr = plan_ptr + 1'b1;
        end
    endtask

    // falls back to a status read where VRAM at the pointer was never written
    task automatic queue_data_read();
        if (vram_written[plan_ptr])
            queue_access(FUNC_READ, PORT_DATA, 8'($urandom));
        else
            queue_access(FUNC_READ, PORT_CTRL, 8'($urandom));
    endtask

    task automatic set_address(input t_cmd cmd, input logic [PTR_W-1:0] addr);
        if (plan_pair)
            queue_access(FUNC_READ, PORT_CTRL, 8'($urandom));
        queue_access(FUNC_WRITE, PORT_CTRL, addr[7:0]);
        queue_access(FUNC_WRITE, PORT_CTRL, {cmd, addr[13:8]});
    endtask

    function automatic logic [PTR_W-1:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return PTR_W'($urandom_range(0, 127));
        else if (sel < 85)
            return 14'h3FC0 + PTR_W'($urandom_range(0, 63));
        else
            return PTR_W'($urandom);
    endfunction

    task automatic queue_random_traffic(input int count);
        int stop_at, sel, len;
        logic [PTR_W-1:0] addr;
        stop_at = queued_count + count;
        while (queued_count < stop_at) begin
            sel = $urandom_range(0, 99);
            len = $urandom_range(1, 8);
            if (sel < 45) begin
                addr = pick_addr();
                last_burst_addr = addr;
                set_address(CMD_VRAM_WR, addr);
                repeat (len) queue_access(FUNC_WRITE, PORT_DATA, 8'($urandom));
                if ($urandom_range(0, 99) < 70) begin
                    set_address(CMD_VRAM_RD, addr);
                    repeat (len) queue_data_read();
                end
            end else if (sel < 60) begin
                addr = ($urandom_range(0, 1) != 0) ? last_burst_addr : pick_addr();
                set_address(CMD_VRAM_RD, addr);
                while (len > 0 && vram_written[plan_ptr]) begin
                    queue_access(FUNC_READ, PORT_DATA, 8'($urandom));
                    len--;
                end
            end else if (sel < 70) begin
                if (plan_pair)
                    queue_access(FUNC_READ, PORT_CTRL, 8'($urandom));
                queue_access(FUNC_WRITE, PORT_CTRL, 8'($urandom));
                queue_access(FUNC_WRITE, PORT_CTRL, {CMD_REG_WR, 6'($urandom)});
            end else if (sel < 80) begin
                set_address(CMD_COLOR_WR, PTR_W'($urandom));
                repeat (len) queue_access(FUNC_WRITE, PORT_DATA, 8'($urandom));
            end else if (sel < 90) begin
                // single access of any kind
                if ($urandom_range(0, 1) != 0)
                    queue_access(FUNC_WRITE, 1'($urandom), 8'($urandom));
                else if ($urandom_range(0, 1) != 0)
                    queue_data_read();
                else
                    queue_access(FUNC_READ, PORT_CTRL, 8'($urandom));
            end else begin
                // pair broken by a status read
                if (plan_pair)
                    queue_access(FUNC_READ, PORT_CTRL, 8'($urandom));
                queue_access(FUNC_WRITE, PORT_CTRL, 8'($urandom));
                queue_access(FUNC_READ, PORT_CTRL, 8'($urandom));
            end
        end
    endtask

    task automatic wait_until_drained();
        while (pending_accesses.size() != 0 || start || expected_reads.size() != 0)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        port_access_t active_access;
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_reads.size());
            $display("video_port_access_decoder test failed");
            $finish;
        end else if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                expected_reads.push_back(predict_access(active_access));
            if (!start || !busy) begin
                if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    active_access = pending_accesses.pop_front();
                    start         <= 1'b1;
                    i_func        <= active_access.is_write;
                    i_port_select <= active_access.is_ctrl;
                    i_bus_byte    <= active_access.bus_byte;
                end else begin
                    start         <= 1'b0;
                    i_func        <= 1'($urandom);
                    i_port_select <= 1'($urandom);
                    i_bus_byte    <= 8'($urandom);
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_result_valid) begin
            if (expected_reads.size() == 0) begin
                $display("%0t: result with no transaction outstanding: expected none, got %02h",
                         $time, o_read_byte);
                mismatch_count++;
            end else begin
                want = expected_reads.pop_front();
                if (o_read_byte !== want) begin
                    $display("%0t: read_byte mismatch: expected %02h, got %02h",
                             $time, want, o_read_byte);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int phase_idle [4];
        phase_idle = '{0, 68, 0, 17};
        for (int i = 0; i < REGISTER_COUNT; i++)
            mode_regs[i] = 8'h00;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pointer wrap on writes and reads, read data byte ignored
        set_address(CMD_VRAM_WR, 14'h3FFE);
        queue_access(FUNC_WRITE, PORT_DATA, 8'h00);
        queue_access(FUNC_WRITE, PORT_DATA, 8'hFF);
        queue_access(FUNC_WRITE, PORT_DATA, 8'hA5);
        queue_access(FUNC_READ, PORT_CTRL, 8'hFF);
        set_address(CMD_VRAM_RD, 14'h3FFE);
        repeat (3) queue_access(FUNC_READ, PORT_DATA, 8'hFF);
        // register writes, top and bottom index; data read under register code
        set_address(CMD_REG_WR, 14'h3FFF);
        queue_data_read();
        set_address(CMD_REG_WR, 14'h0000);
        // color RAM even latch / odd commit into last entry, then a read under color code
        set_address(CMD_COLOR_WR, 14'h3FFE);
        queue_access(FUNC_WRITE, PORT_DATA, 8'h34);
        queue_access(FUNC_WRITE, PORT_DATA, 8'hAB);
        queue_data_read();
        // status read between the two control bytes drops the first one
        queue_access(FUNC_WRITE, PORT_CTRL, 8'h00);
        queue_access(FUNC_READ, PORT_CTRL, 8'h00);
        set_address(CMD_VRAM_RD, 14'h3FFE);
        queue_data_read();

        foreach (phase_idle[p]) begin
            wait_until_drained();
            idle_pct = phase_idle[p];
            queue_random_traffic(100);
        end
        wait_until_drained();
        repeat (SETTLE) @(negedge i_clk);

        $display("%0d transactions: %0d data reads, %0d VRAM writes, %0d color entry writes",
                 queued_count, n_data_reads, n_vram_writes, n_color_writes);
        $display("%0d control pairs, %0d status reads, %0d mismatches",
                 n_ctrl_pairs, n_status_reads, mismatch_count);
        if (mismatch_count == 0)
            $display("video_port_access_decoder test passed");
        else
            $display("video_port_access_decoder test failed");
        $finish;
    end

endmodule
